/* sv/aes_pkg.sv */
// Shared types, constants and GF(2^8) helpers for the AES-128 ECB engine.
package aes_pkg;

  localparam int ROUND_COUNT = 10;
  localparam int RK_IDX_W    = $clog2(ROUND_COUNT + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  valid_bytes;
    logic        last_block;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  kept_bytes;
    logic        padding_error;
    logic        last_out;
  } out_rsp_t;

  typedef struct packed {
    logic busy;
  } key_status_t;

  typedef logic [7:0] sbox_tab_t [256];

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = gf_double(x);
    end
    gf_mul = acc;
  endfunction

  // Inverse as v^254; only used to build the constant tables.
  function automatic logic [7:0] gf_inv(input logic [7:0] v);
    logic [7:0] acc;
    logic [7:0] base;
    logic [7:0] e;
    acc  = 8'h01;
    base = v;
    e    = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) acc = gf_mul(acc, base);
      base = gf_mul(base, base);
    end
    gf_inv = (v == 8'h00) ? 8'h00 : acc;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int s);
    rotl8 = (v << s) | (v >> (8 - s));
  endfunction

  function automatic sbox_tab_t build_sbox(input logic inverse);
    sbox_tab_t  t;
    logic [7:0] x;
    logic [7:0] i;
    logic [7:0] s;
    for (int n = 0; n < 256; n++) begin
      x = n[7:0];
      i = gf_inv(x);
      s = i ^ rotl8(i, 1) ^ rotl8(i, 2) ^ rotl8(i, 3) ^ rotl8(i, 4) ^ 8'h63;
      if (inverse) t[s] = x;
      else         t[x] = s;
    end
    build_sbox = t;
  endfunction

  localparam sbox_tab_t SBOX_FWD = build_sbox(1'b0);
  localparam sbox_tab_t SBOX_INV = build_sbox(1'b1);

endpackage

/* sv/aes128_ecb_cipher_with_padding.sv */
// Top level of the AES-128 ECB engine with PKCS#7-style padding.
// Each request carries one 16-byte block that is encrypted or decrypted under
// the key in the two key registers. From acceptance to the result register,
// the block is loaded at the accepting edge, then goes through the initial key
// add, the ten rounds through the single shared round unit, and the padding
// check with the result load. The first request after reset or after any key
// write first runs the key schedule, one round key per cycle. One request is
// in flight at a time; in_stall stays high from acceptance until the result is
// loaded into the output register. A result may wait in the output register
// while the next request is taken, and a stalled result holds the engine in
// its last step. Key writes must only happen while the engine is idle.
module aes128_ecb_cipher_with_padding (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  aes_pkg::in_req_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output aes_pkg::out_rsp_t              out_data,
  input  logic                           cfg_we,
  input  logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aes_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import aes_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_KEYX, S_INIT, S_ROUND, S_FIN} state_t;

  state_t              state_r;
  logic [63:0]         key_hi_r, key_lo_r;
  logic                keys_ready_r;
  logic [127:0]        st_r;
  logic                op_r, last_r;
  logic [RK_IDX_W-1:0] rnd_r;
  logic                out_valid_r;
  out_rsp_t            out_r;

  logic                in_acc, key_start, out_free;
  logic [RK_IDX_W-1:0] rd_idx;
  logic [127:0]        rk, round_out, padded;
  key_status_t         key_st;
  logic [7:0]          p;
  logic                pad_ok;
  logic [8:0]          pos_sum;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign key_start = in_acc && !keys_ready_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Round key select: decrypt walks the schedule backwards.
  always_comb begin
    if (state_r == S_INIT) rd_idx = op_r ? RK_IDX_W'(ROUND_COUNT) : '0;
    else rd_idx = op_r ? RK_IDX_W'(ROUND_COUNT) - rnd_r : rnd_r;
  end

  aes_key u_key (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (key_start),
    .key    ({key_hi_r, key_lo_r}),
    .rd_idx (rd_idx),
    .rk     (rk),
    .status (key_st)
  );

  aes_round u_round (
    .st_in     (st_r),
    .rk        (rk),
    .dec       (op_r),
    .final_rnd (rnd_r == RK_IDX_W'(ROUND_COUNT)),
    .st_out    (round_out)
  );

  // Encrypt padding: below a valid count of 16, every byte at or past it takes the pad count.
  always_comb begin
    padded = {in_data.block_high, in_data.block_low};
    for (int i = 0; i < 16; i++) begin
      if (in_data.valid_bytes < 5'd16 && 5'(i) >= in_data.valid_bytes)
        padded[127-8*i -: 8] = 8'(5'd16 - in_data.valid_bytes);
    end
  end

  // Padding check on the decrypted block: the last byte names the pad length,
  // and every byte in the pad must repeat it.
  always_comb begin
    p      = st_r[7:0];
    pad_ok = (p >= 8'd1) && (p <= 8'd16);
    for (int i = 0; i < 16; i++) begin
      pos_sum = 9'(i) + {1'b0, p};
      if (pos_sum >= 9'd16 && st_r[127-8*i -: 8] != p) pad_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      key_hi_r     <= '0;
      key_lo_r     <= '0;
      keys_ready_r <= 1'b0;
      rnd_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // A result taken while the next one is being loaded is replaced below.
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_HIGH: begin
            key_hi_r     <= cfg_wdata;
            keys_ready_r <= 1'b0;
          end
          CFG_KEY_LOW: begin
            key_lo_r     <= cfg_wdata;
            keys_ready_r <= 1'b0;
          end
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) state_r <= keys_ready_r ? S_INIT : S_KEYX;
        end
        S_KEYX: begin
          if (!key_st.busy) begin
            keys_ready_r <= 1'b1;
            state_r      <= S_INIT;
          end
        end
        S_INIT: begin
          rnd_r   <= RK_IDX_W'(1);
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          if (rnd_r == RK_IDX_W'(ROUND_COUNT)) state_r <= S_FIN;
          else rnd_r <= rnd_r + RK_IDX_W'(1);
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      op_r   <= in_data.operation;
      last_r <= in_data.last_block;
      st_r   <= in_data.operation ? {in_data.block_high, in_data.block_low} : padded;
    end else if (state_r == S_INIT) begin
      st_r <= st_r ^ rk;
    end else if (state_r == S_ROUND) begin
      st_r <= round_out;
    end
    if (state_r == S_FIN && out_free) begin
      out_r.result_high   <= st_r[127:64];
      out_r.result_low    <= st_r[63:0];
      out_r.last_out      <= last_r;
      out_r.padding_error <= op_r && last_r && !pad_ok;
      if (op_r && last_r) out_r.kept_bytes <= pad_ok ? 5'(9'd16 - {1'b0, p}) : 5'd0;
      else                out_r.kept_bytes <= 5'd16;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/aes_key.sv */
// Round-key expansion: one 128-bit round key per cycle into an 11-row register file.
module aes_key (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [127:0]                 key,
  input  logic [aes_pkg::RK_IDX_W-1:0] rd_idx,
  output logic [127:0]                 rk,
  output aes_pkg::key_status_t         status
);
  import aes_pkg::*;

  logic [127:0]          rk_r [ROUND_COUNT+1];
  logic [127:0]          cur_r;
  logic [127:0]          nxt;
  logic [RK_IDX_W-1:0]   cnt_r;
  logic [7:0]            rc_r;
  logic                  run_r;
  logic [31:0]           w0, w1, w2, w3, t, n0, n1, n2, n3;

  always_comb begin
    w0 = cur_r[127:96];
    w1 = cur_r[95:64];
    w2 = cur_r[63:32];
    w3 = cur_r[31:0];
    t  = {SBOX_FWD[w3[23:16]], SBOX_FWD[w3[15:8]], SBOX_FWD[w3[7:0]], SBOX_FWD[w3[31:24]]}
         ^ {rc_r, 24'h000000};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    nxt = {n0, n1, n2, n3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      rc_r  <= 8'h01;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= RK_IDX_W'(1);
      rc_r  <= 8'h01;
    end else if (run_r) begin
      rc_r  <= gf_double(rc_r);
      cnt_r <= cnt_r + RK_IDX_W'(1);
      if (cnt_r == RK_IDX_W'(ROUND_COUNT)) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rk_r[0] <= key;
      cur_r   <= key;
    end else if (run_r) begin
      rk_r[cnt_r] <= nxt;
      cur_r       <= nxt;
    end
  end

  assign rk          = rk_r[rd_idx];
  assign status.busy = run_r;

endmodule

/* sv/aes_round.sv */
// One AES round, forward or inverse, shared across all rounds of a block.
module aes_round (
  input  logic [127:0] st_in,
  input  logic [127:0] rk,
  input  logic         dec,
  input  logic         final_rnd,
  output logic [127:0] st_out
);
  import aes_pkg::*;

  logic [7:0] a [16];
  logic [7:0] b [16];
  logic [7:0] c [16];
  logic [7:0] d [16];
  logic [7:0] k [16];
  int         src;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      a[i] = st_in[127-8*i -: 8];
      k[i] = rk[127-8*i -: 8];
    end
    // Substitution and row shift commute; do sub first in both directions.
    for (int i = 0; i < 16; i++) b[i] = dec ? SBOX_INV[a[i]] : SBOX_FWD[a[i]];
    for (int r = 0; r < 4; r++) begin
      for (int col = 0; col < 4; col++) begin
        src = dec ? ((col + 4 - r) & 3) : ((col + r) & 3);
        c[r + 4*col] = b[r + 4*src];
      end
    end
    if (dec) begin
      for (int i = 0; i < 16; i++) c[i] = c[i] ^ k[i];
    end
    for (int col = 0; col < 4; col++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec)
          d[4*col+r] = gf_mul(c[4*col + r],           8'd14)
                     ^ gf_mul(c[4*col + ((r+1) & 3)], 8'd11)
                     ^ gf_mul(c[4*col + ((r+2) & 3)], 8'd13)
                     ^ gf_mul(c[4*col + ((r+3) & 3)], 8'd9);
        else
          d[4*col+r] = gf_mul(c[4*col + r],           8'd2)
                     ^ gf_mul(c[4*col + ((r+1) & 3)], 8'd3)
                     ^ c[4*col + ((r+2) & 3)]
                     ^ c[4*col + ((r+3) & 3)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (final_rnd) d[i] = c[i];
      if (!dec) d[i] = d[i] ^ k[i];
      st_out[127-8*i -: 8] = d[i];
    end
  end

endmodule

/* sv/aes_checker.sv */
// Port-level checks for the AES-128 ECB engine, bound to the top level.
module aes_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // Only one request in flight: the engine stalls right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a request was in flight");

  // A new result only appears at the end of a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

  // No result can follow acceptance in the very next cycle.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && !in_stall) |-> !$rose(out_valid))
    else $error("result arrived too early");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result was withdrawn");

endmodule

bind aes128_ecb_cipher_with_padding aes_checker u_aes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

/* dv/aes128_ecb_cipher_with_padding_tb.sv */
// Self-checking testbench for the AES-128 ECB engine with PKCS#7-style padding.
module aes128_ecb_cipher_with_padding_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_req_t in_data;
  logic out_valid;
  logic out_stall;
  out_rsp_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  aes128_ecb_cipher_with_padding dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: the key registers and the expanded round keys.
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [31:0] sched_words [44];
  bit schedule_valid;

  in_req_t pending_reqs[$];
  out_rsp_t expected_rsps[$];
  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int rsp_count;
  int enc_count;
  int dec_count;
  int pad_err_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter with the timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** aes128_ecb_cipher_with_padding: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = xtime(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] ginv(logic [7:0] v);
    logic [7:0] acc;
    logic [7:0] base;
    acc = 8'h01;
    base = v;
    // 254 = 0b11111110: every bit but the lowest contributes.
    for (int i = 0; i < 8; i++) begin
      if (i != 0) acc = gmul(acc, base);
      base = gmul(base, base);
    end
    return (v == 8'h00) ? 8'h00 : acc;
  endfunction

  function automatic logic [7:0] rotl(logic [7:0] v, int s);
    return (v << s) | (v >> (8 - s));
  endfunction

  function automatic logic [7:0] sub_byte(logic [7:0] v);
    logic [7:0] i;
    i = ginv(v);
    return i ^ rotl(i, 1) ^ rotl(i, 2) ^ rotl(i, 3) ^ rotl(i, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sub_byte(logic [7:0] v);
    return ginv(rotl(v, 1) ^ rotl(v, 3) ^ rotl(v, 6) ^ 8'h05);
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] t;
    logic [7:0] rcon;
    rcon = 8'h01;
    sched_words[0] = key_hi_q[63:32];
    sched_words[1] = key_hi_q[31:0];
    sched_words[2] = key_lo_q[63:32];
    sched_words[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched_words[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_byte(t[31:24]), sub_byte(t[23:16]), sub_byte(t[15:8]), sub_byte(t[7:0])};
        t ^= {rcon, 24'h0};
        rcon = xtime(rcon);
      end
      sched_words[i] = sched_words[i-4] ^ t;
    end
    schedule_valid = 1'b1;
  endfunction

  function automatic void add_round_key(inout logic [7:0] s [16], input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[4*c+r] ^= sched_words[4*rnd+c][31-8*r -: 8];
  endfunction

  function automatic void shift_rows(inout logic [7:0] s [16], input bit inverse);
    logic [7:0] t [16];
    int src;
    t = s;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        src = inverse ? (c + 4 - r) % 4 : (c + r) % 4;
        s[r+4*c] = t[r+4*src];
      end
  endfunction

  function automatic void mix_columns(inout logic [7:0] s [16], input bit inverse);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] acc;
    if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gmul(a[k], m[(k - r + 4) % 4]);
        s[4*c+r] = acc;
      end
    end
  endfunction

  // Computes the response the engine must return for one request.
  function automatic out_rsp_t cipher_response(in_req_t req);
    out_rsp_t rsp;
    logic [7:0] s [16];
    logic [4:0] vb;
    logic [7:0] p;
    bit ok;
    if (!schedule_valid) expand_round_keys();
    for (int i = 0; i < 8; i++) begin
      s[i] = req.block_high[63-8*i -: 8];
      s[8+i] = req.block_low[63-8*i -: 8];
    end
    rsp.kept_bytes = 5'd16;
    rsp.padding_error = 1'b0;
    rsp.last_out = req.last_block;
    if (req.operation == 1'b0) begin
      vb = req.valid_bytes;
      // Counts above sixteen mean a full block; zero yields sixteen pad bytes.
      if (vb < 5'd16)
        for (int i = vb; i < 16; i++) s[i] = 8'd16 - vb;
      add_round_key(s, 0);
      for (int rnd = 1; rnd <= ROUND_COUNT; rnd++) begin
        for (int i = 0; i < 16; i++) s[i] = sub_byte(s[i]);
        shift_rows(s, 1'b0);
        if (rnd != ROUND_COUNT) mix_columns(s, 1'b0);
        add_round_key(s, rnd);
      end
    end else begin
      add_round_key(s, ROUND_COUNT);
      for (int rnd = ROUND_COUNT - 1; rnd >= 0; rnd--) begin
        shift_rows(s, 1'b1);
        for (int i = 0; i < 16; i++) s[i] = inv_sub_byte(s[i]);
        add_round_key(s, rnd);
        if (rnd != 0) mix_columns(s, 1'b1);
      end
      if (req.last_block) begin
        p = s[15];
        ok = (p >= 8'd1 && p <= 8'd16);
        if (ok)
          for (int i = 16 - p; i < 16; i++) if (s[i] != p) ok = 1'b0;
        if (ok) begin
          rsp.kept_bytes = 5'(16 - p);
        end else begin
          rsp.kept_bytes = 5'd0;
          rsp.padding_error = 1'b1;
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      rsp.result_high[63-8*i -: 8] = s[i];
      rsp.result_low[63-8*i -: 8] = s[8+i];
    end
    return rsp;
  endfunction

  // Request driver: holds a request until it is taken, then idles at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Prediction happens at acceptance so key changes between phases line up.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_rsps.push_back(cipher_response(in_data));
      if (in_data.operation) dec_count++;
      else enc_count++;
    end
  end

  // Receiver stall and response checker.
  always @(posedge clk) begin
    out_rsp_t exp_rsp;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response %h", $time, out_data);
        error_count++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (exp_rsp.padding_error) pad_err_count++;
        if (out_data.result_high !== exp_rsp.result_high) begin
          $display("%0t: result_high expected %h actual %h", $time,
                   exp_rsp.result_high, out_data.result_high);
          error_count++;
        end
        if (out_data.result_low !== exp_rsp.result_low) begin
          $display("%0t: result_low expected %h actual %h", $time,
                   exp_rsp.result_low, out_data.result_low);
          error_count++;
        end
        if (out_data.kept_bytes !== exp_rsp.kept_bytes) begin
          $display("%0t: kept_bytes expected %0d actual %0d", $time,
                   exp_rsp.kept_bytes, out_data.kept_bytes);
          error_count++;
        end
        if (out_data.padding_error !== exp_rsp.padding_error) begin
          $display("%0t: padding_error expected %b actual %b", $time,
                   exp_rsp.padding_error, out_data.padding_error);
          error_count++;
        end
        if (out_data.last_out !== exp_rsp.last_out) begin
          $display("%0t: last_out expected %b actual %b", $time,
                   exp_rsp.last_out, out_data.last_out);
          error_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_req_t make_req(logic op, logic [63:0] hi, logic [63:0] lo,
                                       logic [4:0] vb, logic last);
    in_req_t r;
    r.operation = op;
    r.block_high = hi;
    r.block_low = lo;
    r.valid_bytes = vb;
    r.last_block = last;
    return r;
  endfunction

  // Builds a ciphertext whose decryption has well-formed padding, or padding
  // broken in one byte, so the padding check sees both outcomes often.
  function automatic in_req_t padded_ciphertext(bit corrupt);
    in_req_t plain;
    out_rsp_t ct;
    logic [4:0] vb;
    int pos;
    vb = 5'($urandom_range(15));
    plain = make_req(1'b0, rand64(), rand64(), vb, 1'b1);
    if (corrupt) begin
      // Write the pad out by hand, then break one pad byte, which may be the
      // last byte itself.
      for (int i = vb; i < 16; i++) begin
        if (i < 8) plain.block_high[63-8*i -: 8] = 8'(16 - vb);
        else plain.block_low[63-8*(i-8) -: 8] = 8'(16 - vb);
      end
      pos = $urandom_range(15, vb);
      if (pos < 8) plain.block_high[63-8*pos -: 8] ^= 8'h01 << $urandom_range(7);
      else plain.block_low[63-8*(pos-8) -: 8] ^= 8'h01 << $urandom_range(7);
      plain.valid_bytes = 5'd16;
    end
    ct = cipher_response(plain);
    return make_req(1'b1, ct.result_high, ct.result_low, 5'($urandom), 1'b1);
  endfunction

  task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_HIGH) key_hi_q = value;
    if (idx == CFG_KEY_LOW) key_lo_q = value;
    if (idx == CFG_KEY_HIGH || idx == CFG_KEY_LOW) schedule_valid = 1'b0;
  endtask

  // Waits until every predicted response has arrived, then lets the engine
  // finish any work still under way.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      // The schedule must stay current while ciphertexts are prepared here.
      if (!schedule_valid) expand_round_keys();
      case (kind)
        0, 1, 2: pending_reqs.push_back(make_req(1'b0, rand64(), rand64(),
                                                 5'($urandom), 1'($urandom)));
        3, 4: pending_reqs.push_back(padded_ciphertext(1'b0));
        5: pending_reqs.push_back(padded_ciphertext(1'b1));
        default: pending_reqs.push_back(make_req(1'($urandom), rand64(), rand64(),
                                                 5'($urandom), 1'($urandom)));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_KEY_HIGH;
    cfg_wdata = '0;
    key_hi_q = '0;
    key_lo_q = '0;
    schedule_valid = 1'b0;
    error_count = 0;
    rsp_count = 0;
    enc_count = 0;
    dec_count = 0;
    pad_err_count = 0;
    cycle_count = 0;
    send_idle_pct = 33;
    recv_idle_pct = 79;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part under the reset key: standard vector, field extremes,
    // padding counts from none to a full pad block, decrypt edge cases.
    schedule_valid = 1'b0;
    pending_reqs.push_back(make_req(1'b0, '0, '0, 5'd16, 1'b0));
    pending_reqs.push_back(make_req(1'b0, '1, '1, 5'd31, 1'b1));
    pending_reqs.push_back(make_req(1'b0, '1, '1, 5'd0, 1'b1));
    pending_reqs.push_back(make_req(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff,
                                    5'd1, 1'b1));
    pending_reqs.push_back(make_req(1'b0, rand64(), rand64(), 5'd15, 1'b0));
    pending_reqs.push_back(make_req(1'b0, rand64(), rand64(), 5'd17, 1'b0));
    pending_reqs.push_back(make_req(1'b1, '0, '0, 5'd0, 1'b0));
    pending_reqs.push_back(make_req(1'b1, '1, '1, 5'd31, 1'b1));
    expand_round_keys();
    pending_reqs.push_back(padded_ciphertext(1'b0));
    pending_reqs.push_back(padded_ciphertext(1'b1));
    drain();

    // Standard test key, then full-ones key, each with random traffic.
    write_key(CFG_KEY_HIGH, 64'h0001020304050607);
    write_key(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    write_key(2'd3, '1);
    pending_reqs.push_back(make_req(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff,
                                    5'd16, 1'b0));
    queue_random(140);
    drain();

    send_idle_pct = 79;
    recv_idle_pct = 33;
    write_key(CFG_KEY_HIGH, '1);
    write_key(CFG_KEY_LOW, '1);
    queue_random(140);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_key(CFG_KEY_HIGH, rand64());
    write_key(CFG_KEY_LOW, rand64());
    queue_random(150);
    drain();

    $display("Checked %0d responses: %0d encrypt and %0d decrypt requests,", rsp_count,
             enc_count, dec_count);
    $display("%0d bad-padding cases, four key settings and three idle profiles.",
             pad_err_count);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("** aes128_ecb_cipher_with_padding: PASSED **");
    end else begin
      $display("** aes128_ecb_cipher_with_padding: FAILED **");
    end
    $finish;
  end

endmodule
